@@ sv/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console cell writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int MAX_ROWS    = 32;
   localparam int MAX_COLUMNS = 128;

   // store index widths and cursor widths (cursor may equal the count)
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int COL_W     = $clog2(MAX_COLUMNS);
   localparam int ADDR_W    = ROW_W + COL_W;
   localparam int CUR_ROW_W = $clog2(MAX_ROWS + 1);
   localparam int CUR_COL_W = $clog2(MAX_COLUMNS + 1);
   localparam int CELL_W    = 16;

   localparam logic [CUR_ROW_W-1:0] ROWS_RESET    = CUR_ROW_W'(25);
   localparam logic [CUR_COL_W-1:0] COLUMNS_RESET = CUR_COL_W'(80);

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE,
      ST_READ_WAIT,
      ST_FILL,
      ST_SCROLL_RD,
      ST_SCROLL_WR,
      ST_SCROLL_BLANK,
      ST_RESULT
   } tcw_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR_STEP,
      OP_LOAD,
      OP_READ,
      OP_CAPTURE,
      OP_SCROLL_INIT,
      OP_SCROLL_READ,
      OP_SCROLL_COPY,
      OP_SCROLL_BLANK,
      OP_ERASE,
      OP_FILL_CELL,
      OP_FILL_END,
      OP_WRITE,
      OP_RESULT
   } tcw_op_type;

   typedef struct packed {
      logic clear_last;
      logic is_read;
      logic filled;
      logic is_lf;
      logic is_cr;
      logic row_at_end;
      logic col_at_end;
      logic copy_more;
      logic x_last;
      logic out_free;
   } tcw_status_type;

endpackage

@@ sv/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the console writer: clear sweep, read, scroll, fill, erase, write, result.
// ----------------------------------------------------------------------------
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  tcw_status_type status,
   output tcw_op_type     op
);

   tcw_state_type state_ff;
   tcw_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      op         = OP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            op = OP_CLEAR_STEP;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op       = OP_LOAD;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.is_read) begin
               op       = OP_READ;
               state_in = ST_READ_WAIT;
            end else if (status.filled && status.is_lf) begin
               state_in = ST_RESULT;
            end else if (status.row_at_end) begin
               // pending scroll, also after a wrap onto the row count
               op       = OP_SCROLL_INIT;
               state_in = ST_SCROLL_RD;
            end else if (status.is_cr) begin
               op       = OP_ERASE;
               state_in = ST_RESULT;
            end else if (!status.filled && (status.is_lf || status.col_at_end)) begin
               state_in = ST_FILL;
            end else begin
               op       = OP_WRITE;
               state_in = ST_RESULT;
            end
         end
         ST_READ_WAIT: begin
            op       = OP_CAPTURE;
            state_in = ST_RESULT;
         end
         ST_FILL: begin
            if (status.col_at_end) begin
               op       = OP_FILL_END;
               state_in = ST_DECIDE;
            end else begin
               op = OP_FILL_CELL;
            end
         end
         ST_SCROLL_RD: begin
            if (status.copy_more) begin
               op       = OP_SCROLL_READ;
               state_in = ST_SCROLL_WR;
            end else begin
               state_in = ST_SCROLL_BLANK;
            end
         end
         ST_SCROLL_WR: begin
            op       = OP_SCROLL_COPY;
            state_in = ST_SCROLL_RD;
         end
         ST_SCROLL_BLANK: begin
            op = OP_SCROLL_BLANK;
            if (status.x_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_RESULT: begin
            if (status.out_free) begin
               op       = OP_RESULT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

@@ sv/tcw_dpath.sv @@
// ----------------------------------------------------------------------------
// tcw_dpath
// Screen store, cursor, walk counters and result register of the console.
// ----------------------------------------------------------------------------
module tcw_dpath
   import tcw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  tcw_op_type           op,
   output tcw_status_type       status,
   input  logic                 req_mode,
   input  logic [7:0]           req_character,
   input  logic [3:0]           req_background,
   input  logic [3:0]           req_foreground,
   input  logic [ROW_W-1:0]     req_read_row,
   input  logic [COL_W-1:0]     req_read_column,
   input  logic [CUR_ROW_W-1:0] rows_in_use,
   input  logic [CUR_COL_W-1:0] columns_in_use,
   input  logic                 rsp_tready,
   output logic                 rsp_valid,
   output logic [CELL_W-1:0]    rsp_cell_value,
   output logic [CUR_ROW_W-1:0] rsp_cursor_row,
   output logic [CUR_COL_W-1:0] rsp_cursor_column,
   output logic                 rsp_scrolled
);

   logic [CELL_W-1:0] mem [0:(1 << ADDR_W)-1];
   logic [CELL_W-1:0] mem_rdata_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;

   logic              mode_ff;
   logic [7:0]        ch_ff;
   logic [3:0]        bg_ff;
   logic [3:0]        fg_ff;
   logic [ROW_W-1:0]  rrow_ff;
   logic [COL_W-1:0]  rcol_ff;

   logic [CUR_ROW_W-1:0] row_ff, row_in;
   logic [CUR_COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0]     y_ff, y_in;
   logic [COL_W-1:0]     x_ff, x_in;
   logic                 filled_ff, filled_in;
   logic                 scrolled_ff, scrolled_in;
   logic [CELL_W-1:0]    cell_ff, cell_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]    rsp_cell_ff;
   logic [CUR_ROW_W-1:0] rsp_row_ff;
   logic [CUR_COL_W-1:0] rsp_col_ff;
   logic                 rsp_scrolled_ff;

   logic [CUR_ROW_W-1:0] nr;
   logic [CUR_COL_W-1:0] nc;
   logic [CUR_ROW_W-1:0] nr_m1;
   logic [CELL_W-1:0]    blank;
   logic [CUR_ROW_W-1:0] er_row;
   logic [CUR_COL_W-1:0] er_col;
   logic                 x_last;

   // effective counts, clamped to the store size, with a count of zero taken as one
   always_comb begin
      nr = rows_in_use;
      if (rows_in_use == '0) begin
         nr = CUR_ROW_W'(1);
      end else if (rows_in_use > CUR_ROW_W'(MAX_ROWS)) begin
         nr = CUR_ROW_W'(MAX_ROWS);
      end
      nc = columns_in_use;
      if (columns_in_use == '0) begin
         nc = CUR_COL_W'(1);
      end else if (columns_in_use > CUR_COL_W'(MAX_COLUMNS)) begin
         nc = CUR_COL_W'(MAX_COLUMNS);
      end
   end

   assign nr_m1  = nr - CUR_ROW_W'(1);
   assign blank  = {bg_ff, 12'h000};
   assign x_last = (CUR_COL_W'(x_ff) == (nc - CUR_COL_W'(1)));

   // backward erase, wrapping to the last column of the row above (column 0 of the top row stays put)
   always_comb begin
      er_row = row_ff;
      er_col = col_ff - CUR_COL_W'(1);
      if (col_ff == '0) begin
         er_col = '0;
         if (row_ff != '0) begin
            er_row = row_ff - CUR_ROW_W'(1);
            er_col = nc - CUR_COL_W'(1);
         end
      end
   end

   always_comb begin
      status.clear_last = &{y_ff, x_ff};
      status.is_read    = mode_ff;
      status.filled     = filled_ff;
      status.is_lf      = (ch_ff == CHAR_LF);
      status.is_cr      = (ch_ff == CHAR_CR);
      status.row_at_end = (row_ff == nr);
      status.col_at_end = (col_ff == nc);
      status.copy_more  = ((CUR_ROW_W'(y_ff) + CUR_ROW_W'(1)) < nr);
      status.x_last     = x_last;
      status.out_free   = !rsp_valid_ff || rsp_tready;
   end

   // store write port
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {y_ff, x_ff};
      mem_wdata = blank;
      case (op)
         OP_CLEAR_STEP: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
         end
         OP_SCROLL_COPY: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata_ff;
         end
         OP_SCROLL_BLANK: begin
            mem_we    = 1'b1;
            mem_waddr = {nr_m1[ROW_W-1:0], x_ff};
         end
         OP_ERASE: begin
            mem_we    = 1'b1;
            mem_waddr = {er_row[ROW_W-1:0], er_col[COL_W-1:0]};
         end
         OP_FILL_CELL: begin
            mem_we    = 1'b1;
            mem_waddr = {row_ff[ROW_W-1:0], col_ff[COL_W-1:0]};
         end
         OP_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = {row_ff[ROW_W-1:0], col_ff[COL_W-1:0]};
            mem_wdata = {bg_ff, fg_ff, ch_ff};
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   assign mem_raddr = (op == OP_SCROLL_READ) ? {y_ff + ROW_W'(1), x_ff} : {rrow_ff, rcol_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      y_in         = y_ff;
      x_in         = x_ff;
      filled_in    = filled_ff;
      scrolled_in  = scrolled_ff;
      cell_in      = cell_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (op)
         OP_CLEAR_STEP: begin
            {y_in, x_in} = {y_ff, x_ff} + ADDR_W'(1);
         end
         OP_LOAD: begin
            filled_in   = 1'b0;
            scrolled_in = 1'b0;
            // a shrunk screen leaves the cursor past the end: pin it
            if (!req_mode) begin
               if (row_ff > nr) begin
                  row_in = nr;
               end
               if (col_ff > nc) begin
                  col_in = nc;
               end
            end
         end
         OP_CAPTURE: begin
            cell_in = mem_rdata_ff;
         end
         OP_SCROLL_INIT: begin
            y_in = '0;
            x_in = '0;
         end
         OP_SCROLL_COPY: begin
            if (x_last) begin
               x_in = '0;
               y_in = y_ff + ROW_W'(1);
            end else begin
               x_in = x_ff + COL_W'(1);
            end
         end
         OP_SCROLL_BLANK: begin
            x_in = x_ff + COL_W'(1);
            if (x_last) begin
               row_in      = nr_m1;
               scrolled_in = 1'b1;
            end
         end
         OP_ERASE: begin
            row_in  = er_row;
            col_in  = er_col;
            cell_in = blank;
         end
         OP_FILL_CELL: begin
            col_in = col_ff + CUR_COL_W'(1);
         end
         OP_FILL_END: begin
            row_in    = row_ff + CUR_ROW_W'(1);
            col_in    = '0;
            filled_in = 1'b1;
            cell_in   = blank;
         end
         OP_WRITE: begin
            col_in  = col_ff + CUR_COL_W'(1);
            cell_in = {bg_ff, fg_ff, ch_ff};
         end
         OP_RESULT: begin
            rsp_valid_in = 1'b1;
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_tready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         y_ff         <= '0;
         x_ff         <= '0;
         filled_ff    <= 1'b0;
         scrolled_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         y_ff         <= y_in;
         x_ff         <= x_in;
         filled_ff    <= filled_in;
         scrolled_ff  <= scrolled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      if (op == OP_LOAD) begin
         mode_ff <= req_mode;
         ch_ff   <= req_character;
         bg_ff   <= req_background;
         fg_ff   <= req_foreground;
         rrow_ff <= req_read_row;
         rcol_ff <= req_read_column;
      end
      if (op == OP_RESULT) begin
         rsp_cell_ff     <= mode_ff ? cell_ff : cell_ff;
         rsp_row_ff      <= row_ff;
         rsp_col_ff      <= col_ff;
         rsp_scrolled_ff <= scrolled_ff && !mode_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_value    = rsp_cell_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_column = rsp_col_ff;
   assign rsp_scrolled      = rsp_scrolled_ff;

   // a put never ends with the cursor past the screen
   assert property (@(posedge clock) disable iff (reset)
      (op == OP_RESULT && !mode_ff) |-> (row_ff <= nr && col_ff <= nc))
      else $error("cursor beyond screen at end of put");

   // scroll copy only writes rows above the bottom one
   assert property (@(posedge clock) disable iff (reset)
      (op == OP_SCROLL_COPY) |-> ((CUR_ROW_W'(y_ff) + CUR_ROW_W'(1)) < nr))
      else $error("scroll copy past the last row");

   // a new result only appears after the result command
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(op) == OP_RESULT))
      else $error("result valid without result command");

   // character and fill writes always land inside the screen
   assert property (@(posedge clock) disable iff (reset)
      (op == OP_WRITE || op == OP_FILL_CELL) |-> (row_ff < nr && col_ff < nc))
      else $error("cell write outside the screen");

endmodule

@@ sv/text_console_cell_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Text-mode console: screen store of 16-bit cells, cursor and scroll engine.
// ----------------------------------------------------------------------------
// One request is handled at a time; the request port is ready only when the
// sequencer is idle, and a finished response waits in an output register while
// the next request is accepted. After reset the store is cleared one cell per
// cycle, all 4096 cells, before the first request is taken (register writes
// are taken as ever). A newline or row wrap first blanks the rest of the row
// cell by cell; a scroll copies each cell of the rows below the top one up a
// row, a read and then a write of the store per cell, and then blanks the
// bottom row cell by cell. A response still held in the output register when
// the next one is done stalls the sequencer until it leaves.
module text_console_cell_writer
   import tcw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] character, [11:8] background, [15:12] foreground,
   // [20:16] read_row, [27:21] read_column, [31:28] zero
   input  logic [31:0] req_tdata,
   // [0] mode
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] cell_value, [21:16] cursor_row, [29:22] cursor_column,
   // [30] scrolled, [31] zero
   output logic [31:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [CUR_ROW_W-1:0] rows_ff, rows_in;
   logic [CUR_COL_W-1:0] cols_ff, cols_in;
   logic                 csr_write;

   tcw_op_type     op;
   tcw_status_type status;

   logic [CELL_W-1:0]    cell_value;
   logic [CUR_ROW_W-1:0] cursor_row;
   logic [CUR_COL_W-1:0] cursor_column;
   logic                 scrolled;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register 0 at byte 0, register 1 at byte 4
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_write) begin
         if (csr_paddr[2]) begin
            cols_in = csr_pwdata[CUR_COL_W-1:0];
         end else begin
            rows_in = csr_pwdata[CUR_ROW_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROWS_RESET;
         cols_ff <= COLUMNS_RESET;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   assign csr_prdata = csr_paddr[2] ? {{(32 - CUR_COL_W){1'b0}}, cols_ff}
                                    : {{(32 - CUR_ROW_W){1'b0}}, rows_ff};

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .op         (op)
   );

   tcw_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .status            (status),
      .req_mode          (req_tuser),
      .req_character     (req_tdata[7:0]),
      .req_background    (req_tdata[11:8]),
      .req_foreground    (req_tdata[15:12]),
      .req_read_row      (req_tdata[20:16]),
      .req_read_column   (req_tdata[27:21]),
      .rows_in_use       (rows_ff),
      .columns_in_use    (cols_ff),
      .rsp_tready        (rsp_tready),
      .rsp_valid         (rsp_tvalid),
      .rsp_cell_value    (cell_value),
      .rsp_cursor_row    (cursor_row),
      .rsp_cursor_column (cursor_column),
      .rsp_scrolled      (scrolled)
   );

   assign rsp_tdata = {1'b0, scrolled, cursor_column, cursor_row, cell_value};

endmodule

@@ dv/text_console_cell_checker.sv @@
// ----------------------------------------------------------------------------
// text_console_cell_checker
// Watches the request, response and register ports of the console writer,
// keeps its own screen, cursor and geometry, and compares every response
// field by field against the predicted one. Also holds the packed layouts of
// the request and response words shared with the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package console_tb_pkg;

   localparam logic MODE_PUT  = 1'b0;
   localparam logic MODE_READ = 1'b1;

   localparam logic [2:0] REG_ROWS_ADDR    = 3'd0;
   localparam logic [2:0] REG_COLUMNS_ADDR = 3'd4;

   // request word, lowest field last
   typedef struct packed {
      logic [3:0] pad;
      logic [6:0] read_column;
      logic [4:0] read_row;
      logic [3:0] foreground;
      logic [3:0] background;
      logic [7:0] character;
   } console_fields_type;

   // response word, lowest field last
   typedef struct packed {
      logic       pad;
      logic       scrolled;
      logic [7:0] cursor_column;
      logic [5:0] cursor_row;
      logic [15:0] cell_value;
   } console_result_type;

endpackage

module text_console_cell_checker
   import tcw_pkg::*;
   import console_tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          failure_count,
   output int          pending_count,
   output int          scroll_count
);

   logic [15:0]        screen [MAX_ROWS][MAX_COLUMNS];
   int unsigned        cursor_row_now;
   int unsigned        cursor_col_now;
   logic [5:0]         rows_reg;
   logic [7:0]         cols_reg;
   console_result_type expected_results[$];
   int                 fail_total = 0;
   int                 scroll_total = 0;

   function automatic void scroll_screen(input int unsigned nr, input int unsigned nc,
                                         input logic [15:0] blank);
      for (int unsigned y = 0; y + 1 < nr; y++)
         for (int unsigned x = 0; x < nc; x++)
            screen[y][x] = screen[y + 1][x];
      for (int unsigned x = 0; x < nc; x++)
         screen[nr - 1][x] = blank;
   endfunction

   function automatic console_result_type predict_console_step(input logic mode,
                                                               input console_fields_type rq);
      int unsigned        nr;
      int unsigned        nc;
      int unsigned        row;
      int unsigned        col;
      logic [15:0]        blank;
      console_result_type res;
      res = '0;
      if (mode == MODE_READ) begin
         if (rq.read_row < MAX_ROWS && rq.read_column < MAX_COLUMNS)
            res.cell_value = screen[rq.read_row][rq.read_column];
         res.cursor_row    = 6'(cursor_row_now);
         res.cursor_column = 8'(cursor_col_now);
         return res;
      end
      nr    = (rows_reg == 0) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);
      nc    = (cols_reg == 0) ? 1 : ((cols_reg > MAX_COLUMNS) ? MAX_COLUMNS : cols_reg);
      row   = (cursor_row_now > nr) ? nr : cursor_row_now;
      col   = (cursor_col_now > nc) ? nc : cursor_col_now;
      blank = {rq.background, 12'h000};

      // pending scroll left over from the previous put
      if (row == nr) begin
         scroll_screen(nr, nc, blank);
         row = nr - 1;
         res.scrolled = 1'b1;
      end

      if (rq.character == CHAR_CR) begin
         if (col == 0) begin
            if (row != 0) begin
               row = row - 1;
               col = nc - 1;
            end
         end else begin
            col = col - 1;
         end
         screen[row][col] = blank;
         res.cell_value = blank;
      end else begin
         if (rq.character == CHAR_LF || col == nc) begin
            for (int unsigned i = col; i < nc; i++)
               screen[row][i] = blank;
            row = row + 1;
            col = 0;
            res.cell_value = blank;
         end
         if (rq.character != CHAR_LF) begin
            // wrapped onto the row past the bottom: scroll before writing
            if (row == nr) begin
               scroll_screen(nr, nc, blank);
               row = nr - 1;
               res.scrolled = 1'b1;
            end
            res.cell_value = {rq.background, rq.foreground, rq.character};
            screen[row][col] = res.cell_value;
            col = col + 1;
         end
      end
      cursor_row_now    = row;
      cursor_col_now    = col;
      res.cursor_row    = 6'(row);
      res.cursor_column = 8'(col);
      return res;
   endfunction

   function automatic void check_field(input string field_name, input int unsigned want,
                                       input int unsigned got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field_name, want, got);
         fail_total++;
      end
   endfunction

   always @(posedge clock) begin
      console_result_type want;
      console_result_type got;
      if (reset) begin
         for (int y = 0; y < MAX_ROWS; y++)
            for (int x = 0; x < MAX_COLUMNS; x++)
               screen[y][x] = '0;
         cursor_row_now = 0;
         cursor_col_now = 0;
         rows_reg = ROWS_RESET;
         cols_reg = COLUMNS_RESET;
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == REG_ROWS_ADDR)
               rows_reg = csr_pwdata[5:0];
            else if (csr_paddr == REG_COLUMNS_ADDR)
               cols_reg = csr_pwdata[7:0];
         end
         // responses first so a request taken at the same edge cannot match itself
         if (rsp_tvalid && rsp_tready) begin
            got = console_result_type'(rsp_tdata);
            if (expected_results.size() == 0) begin
               $error("response 0x%08h with no request waiting", rsp_tdata);
               fail_total++;
            end else begin
               want = expected_results.pop_front();
               check_field("cell_value", want.cell_value, got.cell_value);
               check_field("cursor_row", want.cursor_row, got.cursor_row);
               check_field("cursor_column", want.cursor_column, got.cursor_column);
               check_field("scrolled", want.scrolled, got.scrolled);
            end
         end
         if (req_tvalid && req_tready) begin
            want = predict_console_step(req_tuser, console_fields_type'(req_tdata));
            if (want.scrolled)
               scroll_total++;
            expected_results.push_back(want);
         end
      end
      failure_count <= fail_total;
      pending_count <= expected_results.size();
      scroll_count  <= scroll_total;
   end

endmodule

@@ dv/tb_text_console_cell_writer.sv @@
// ----------------------------------------------------------------------------
// tb_text_console_cell_writer
// Drives character and read requests into the console writer under a range
// of screen geometries, with random gaps and response stalls, and reports
// the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_console_cell_writer;
   import tcw_pkg::*;
   import console_tb_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 5_000_000;
   localparam int unsigned DRAIN_CYCLES    = 20;
   localparam int unsigned HOLD_OFF_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          failure_count;
   int          pending_count;
   int          scroll_count;
   int unsigned cycle_count = 0;
   int unsigned sent_total;
   int unsigned geometry_total;
   bit          no_gaps;
   bit          hold_off_request;

   text_console_cell_writer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   text_console_cell_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .failure_count (failure_count),
      .pending_count (pending_count),
      .scroll_count  (scroll_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int unsigned stall;
      bit          hold_taken;
      hold_taken = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         if (hold_off_request && !hold_taken) begin
            hold_taken = 1'b1;
            repeat (HOLD_OFF_CYCLES) begin
               @(negedge clock);
               rsp_tready = 1'b0;
            end
         end
         stall = no_gaps ? 0 : $urandom_range(0, 8);
         repeat (stall) begin
            @(negedge clock);
            rsp_tready = 1'b0;
         end
         @(negedge clock);
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_request(input logic mode, input console_fields_type f);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = f;
      do @(posedge clock); while (!req_tready);
      sent_total++;
   endtask

   task automatic put_char(input logic [7:0] ch, input logic [3:0] bg, input logic [3:0] fg);
      console_fields_type f;
      f = '0;
      f.character  = ch;
      f.background = bg;
      f.foreground = fg;
      f.read_row    = 5'($urandom_range(0, 31));
      f.read_column = 7'($urandom_range(0, 127));
      send_request(MODE_PUT, f);
   endtask

   task automatic read_cell(input logic [4:0] r, input logic [6:0] c);
      console_fields_type f;
      f = '0;
      f.character   = 8'($urandom_range(0, 255));
      f.background  = 4'($urandom_range(0, 15));
      f.foreground  = 4'($urandom_range(0, 15));
      f.read_row    = r;
      f.read_column = c;
      send_request(MODE_READ, f);
   endtask

   // drop valid, then wait until every outstanding request has its response
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic set_geometry(input logic [5:0] rows_val, input logic [7:0] cols_val);
      wait_idle();
      csr_write(REG_ROWS_ADDR, {26'd0, rows_val});
      csr_write(REG_COLUMNS_ADDR, {24'd0, cols_val});
      geometry_total++;
   endtask

   task automatic send_random(input int unsigned nr, input int unsigned nc);
      int unsigned        pick;
      logic               mode;
      console_fields_type f;
      f = '0;
      f.character  = 8'($urandom_range(0, 255));
      f.background = 4'($urandom_range(0, 15));
      f.foreground = 4'($urandom_range(0, 15));
      // reads land on the visible screen half the time, otherwise anywhere in the store
      if ($urandom_range(0, 1) == 0) begin
         f.read_row    = 5'($urandom_range(0, nr - 1));
         f.read_column = 7'($urandom_range(0, nc - 1));
      end else begin
         f.read_row    = 5'($urandom_range(0, 31));
         f.read_column = 7'($urandom_range(0, 127));
      end
      pick = $urandom_range(0, 99);
      mode = MODE_PUT;
      if (pick < 15)
         mode = MODE_READ;
      else if (pick < 29)
         f.character = CHAR_LF;
      else if (pick < 40)
         f.character = CHAR_CR;
      send_request(mode, f);
   endtask

   task automatic run_phase(input logic [5:0] rows_val, input logic [7:0] cols_val,
                            input int unsigned count, input bit long_hold);
      int unsigned nr;
      int unsigned nc;
      set_geometry(rows_val, cols_val);
      nr = (rows_val == 0) ? 1 : ((rows_val > MAX_ROWS) ? MAX_ROWS : rows_val);
      nc = (cols_val == 0) ? 1 : ((cols_val > MAX_COLUMNS) ? MAX_COLUMNS : cols_val);
      for (int unsigned k = 0; k < count; k++) begin
         if (k % 32 == 0)
            no_gaps = ($urandom_range(0, 3) == 0);
         // response side stalls while requests keep coming
         if (long_hold && k == 10)
            hold_off_request = 1'b1;
         send_random(nr, nc);
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = MODE_PUT;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = REG_ROWS_ADDR;
      csr_pwdata       = '0;
      no_gaps          = 1'b0;
      hold_off_request = 1'b0;
      sent_total       = 0;
      geometry_total   = 1;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // geometry left at its reset value
      put_char(8'h5A, 4'h1, 4'hE);
      put_char(CHAR_LF, 4'h2, 4'h0);
      read_cell(5'd0, 7'd0);

      // two rows of four cells make wraps and scrolls cheap to reach
      set_geometry(6'd2, 8'd4);
      read_cell(5'd0, 7'd0);
      read_cell(5'd31, 7'd127);
      put_char(CHAR_CR, 4'hF, 4'h0);
      put_char(8'h41, 4'hF, 4'h0);
      put_char(8'hFF, 4'h0, 4'hF);
      put_char(8'h00, 4'h5, 4'hA);
      put_char(8'h7E, 4'h3, 4'hC);
      put_char(8'h42, 4'h1, 4'h2);
      put_char(CHAR_CR, 4'h8, 4'h1);
      put_char(CHAR_CR, 4'h9, 4'h1);
      put_char(CHAR_LF, 4'h6, 4'h0);
      put_char(CHAR_LF, 4'h7, 4'h0);
      put_char(8'h43, 4'h2, 4'h3);
      put_char(8'h44, 4'h2, 4'h4);
      put_char(8'h45, 4'h2, 4'h5);
      put_char(8'h46, 4'h2, 4'h6);
      put_char(8'h47, 4'hA, 4'h7);
      put_char(CHAR_LF, 4'hB, 4'h0);
      put_char(CHAR_CR, 4'hC, 4'h0);
      put_char(CHAR_LF, 4'hD, 4'h0);
      put_char(CHAR_LF, 4'hE, 4'h0);
      put_char(CHAR_LF, 4'h4, 4'h0);
      read_cell(5'd0, 7'd3);
      read_cell(5'd1, 7'd0);
      read_cell(5'd1, 7'd3);

      run_phase(6'd1, 8'd1, 80, 1'b0);
      run_phase(6'd0, 8'd0, 60, 1'b0);
      run_phase(6'd3, 8'd8, 250, 1'b0);
      run_phase(6'd4, 8'd5, 250, 1'b0);
      run_phase(6'd63, 8'd255, 30, 1'b0);
      run_phase(6'd5, 8'd3, 250, 1'b0);
      run_phase(6'd32, 8'd128, 30, 1'b0);
      run_phase(6'd8, 8'd16, 250, 1'b1);
      run_phase(6'd2, 8'd128, 60, 1'b0);
      run_phase(6'd32, 8'd1, 60, 1'b0);
      run_phase(6'd6, 8'd10, 200, 1'b0);
      run_phase(6'd25, 8'd80, 30, 1'b0);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests on %0d screen geometries, %0d of them scrolled",
               sent_total, geometry_total, scroll_count);
      if (failure_count == 0 && pending_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
